/* hdl/assert_macros.svh */
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked implication, off while reset is asserted
`define ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

/* hdl/arpc_pkg.sv */
// types and constants of the arp parser and cache
`default_nettype none
package arpc_pkg;

    localparam logic [4:0]  PKT_LEN    = 5'd28;
    localparam logic [15:0] OPER_REQ   = 16'd1;
    localparam logic [15:0] OPER_REPLY = 16'd2;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_LOOKUP  = 1'b1;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // token that runs down the row of cache cells
    typedef struct packed {
        logic        valid;
        logic        learn;
        logic        hit;
        logic        free_found;
        logic [31:0] ip;
        logic [47:0] mac;
    } tok_t;

    // broadcast write into one cell
    typedef struct packed {
        logic        en;
        logic [31:0] ip;
        logic [47:0] mac;
    } wr_t;

    // packet verdict as seen with the current byte absorbed
    typedef struct packed {
        logic        ok;
        logic        reply;
        logic [47:0] mac;
        logic [31:0] ip;
    } verdict_t;

    typedef struct packed {
        logic        kind;
        logic        success;
        logic        reply;
        logic [47:0] mac;
        logic [31:0] ip;
    } res_t;

    // expected header bytes: htype 1, ptype 0x0800, hlen 6, plen 4
    function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = 8'h00;
            3'd1:    b = 8'h01;
            3'd2:    b = 8'h08;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h04;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

/* hdl/arpc_if.sv */
// item and result channel interfaces
`default_nettype none
interface arpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] query_ip;

    modport source (output valid, op, data_byte, last_byte, query_ip, input ready);
    modport sink   (input valid, op, data_byte, last_byte, query_ip, output ready);
endinterface

interface arpc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        success;
    logic        reply_needed;
    logic [47:0] mac;
    logic [31:0] ip;

    modport source (output valid, result_kind, success, reply_needed, mac, ip, input ready);
    modport sink   (input valid, result_kind, success, reply_needed, mac, ip, output ready);
endinterface
`default_nettype wire

/* hdl/arpc_parse.sv */
// byte-wise arp header parser with verdict of the packet so far
`default_nettype none
module arpc_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_en,
    input  logic                 last_byte,
    input  logic [7:0]           data_byte,
    input  logic [31:0]          own_ip,
    output arpc_pkg::verdict_t   verdict
);
    import arpc_pkg::*;

    logic [4:0]  count_reg, count_next;
    logic        hm_reg, hm_next;
    logic [15:0] oper_reg, oper_next;
    logic [47:0] smac_reg, smac_next;
    logic [31:0] sip_reg, sip_next;
    logic [31:0] tip_reg, tip_next;
    logic        absorb;

    always_comb
    begin
        absorb     = count_reg < PKT_LEN;
        count_next = count_reg;
        hm_next    = hm_reg;
        oper_next  = oper_reg;
        smac_next  = smac_reg;
        sip_next   = sip_reg;
        tip_next   = tip_reg;
        if (absorb)
        begin
            count_next = count_reg + 5'd1;
            if (count_reg < 5'd6)
            begin
                if (data_byte != hdr_byte(count_reg[2:0]))
                begin
                    hm_next = 1'b0;
                end
            end
            else if (count_reg < 5'd8)
            begin
                oper_next = {oper_reg[7:0], data_byte};
            end
            else if (count_reg < 5'd14)
            begin
                smac_next = {smac_reg[39:0], data_byte};
            end
            else if (count_reg < 5'd18)
            begin
                sip_next = {sip_reg[23:0], data_byte};
            end
            else if (count_reg >= 5'd24)
            begin
                tip_next = {tip_reg[23:0], data_byte};
            end
        end
        verdict.ok    = hm_next && (count_next >= PKT_LEN)
                        && (oper_next == OPER_REQ || oper_next == OPER_REPLY);
        verdict.reply = (oper_next == OPER_REQ) && (tip_next == own_ip);
        verdict.mac   = smac_next;
        verdict.ip    = sip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hm_reg    <= 1'b1;
            oper_reg  <= '0;
            smac_reg  <= '0;
            sip_reg   <= '0;
            tip_reg   <= '0;
        end
        else if (byte_en)
        begin
            if (last_byte)
            begin
                // packet ends: back to a fresh parse
                count_reg <= '0;
                hm_reg    <= 1'b1;
                oper_reg  <= '0;
                smac_reg  <= '0;
                sip_reg   <= '0;
                tip_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                hm_reg    <= hm_next;
                oper_reg  <= oper_next;
                smac_reg  <= smac_next;
                sip_reg   <= sip_next;
                tip_reg   <= tip_next;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/arpc_cell.sv */
// one cache entry with its stage of the search token chain
`default_nettype none
module arpc_cell #(
    parameter int IDX_W = 3,
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  arpc_pkg::wr_t      wr,
    input  logic [IDX_W-1:0]   wr_idx,
    input  arpc_pkg::tok_t     tok_in,
    input  logic [IDX_W-1:0]   idx_in,
    output arpc_pkg::tok_t     tok_out,
    output logic [IDX_W-1:0]   idx_out
);
    import arpc_pkg::*;

    logic             valid_reg;
    logic [31:0]      ip_reg;
    logic [47:0]      mac_reg;
    tok_t             tok_reg, tok_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             match;
    logic             sel;

    assign match = valid_reg && (ip_reg == tok_in.ip);
    assign sel   = wr.en && (wr_idx == IDX_W'(INDEX));

    always_comb
    begin
        tok_next = tok_in;
        idx_next = idx_in;
        if (tok_in.valid)
        begin
            if (match && !tok_in.hit)
            begin
                tok_next.hit = 1'b1;
                if (!tok_in.learn)
                begin
                    tok_next.mac = mac_reg;
                end
            end
            // lowest free entry wins
            if (tok_in.learn && !valid_reg && !tok_in.free_found)
            begin
                tok_next.free_found = 1'b1;
                idx_next            = IDX_W'(INDEX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (clear)
            begin
                valid_reg <= 1'b0;
            end
            else if (sel)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (sel)
        begin
            ip_reg  <= wr.ip;
            mac_reg <= wr.mac;
        end
        else if (tok_in.valid && tok_in.learn && match)
        begin
            mac_reg <= tok_in.mac;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule
`default_nettype wire

/* hdl/arp_parse_and_cache.sv */
// arp parser and ip-to-mac cache, top level
// payload bytes without a learn: one item per cycle, stalled by a walk or a full slot;
//   no result, or a verdict in the next cycle; learn and lookup: a token walks the row
//   of CACHE_ENTRIES cells one cell per cycle, result registered as it leaves the row,
//   next item taken when it leaves; clear: all entries invalid, replace pointer to zero
// rst_n clears the cache, the parse state and the own ip register at once
`default_nettype none
module arp_parse_and_cache #(
    parameter int CACHE_ENTRIES = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    arpc_in_if.sink      items,
    arpc_out_if.source   results,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import arpc_pkg::*;
    `include "assert_macros.svh"

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    state_t           state_reg, state_next;
    logic [31:0]      own_ip_reg;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             reply_reg;
    logic             out_valid_reg;
    res_t             res_reg, res_next;
    logic             res_load;

    logic             accept;
    logic             is_byte, is_last, is_lookup, is_clear;
    verdict_t         verdict;
    tok_t             tok_launch;
    wr_t              wr;
    logic [IDX_W-1:0] wr_idx;

    tok_t             tok_chain [0:CACHE_ENTRIES];
    logic [IDX_W-1:0] idx_chain [0:CACHE_ENTRIES];
    tok_t             tok_end;
    logic [IDX_W-1:0] idx_end;

    // configuration port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : own_ip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg <= '0;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            own_ip_reg <= pwdata;
        end
    end

    assign items.ready = (state_reg == ST_IDLE) && (!out_valid_reg || results.ready);

    assign accept    = items.valid && items.ready;
    assign is_byte   = accept && (items.op == OP_BYTE);
    assign is_last   = is_byte && items.last_byte;
    assign is_lookup = accept && (items.op == OP_LOOKUP);
    assign is_clear  = accept && (items.op == OP_CLEAR);

    arpc_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (is_byte),
        .last_byte (items.last_byte),
        .data_byte (items.data_byte),
        .own_ip    (own_ip_reg),
        .verdict   (verdict)
    );

    always_comb
    begin
        tok_launch.valid      = (is_last && verdict.ok) || is_lookup;
        tok_launch.learn      = !is_lookup;
        tok_launch.hit        = 1'b0;
        tok_launch.free_found = 1'b0;
        tok_launch.ip         = is_lookup ? items.query_ip : verdict.ip;
        tok_launch.mac        = is_lookup ? 48'd0 : verdict.mac;
    end

    assign tok_chain[0] = tok_launch;
    assign idx_chain[0] = '0;

    for (genvar i = 0; i < CACHE_ENTRIES; i++)
    begin : g_cell
        arpc_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (is_clear),
            .wr      (wr),
            .wr_idx  (wr_idx),
            .tok_in  (tok_chain[i]),
            .idx_in  (idx_chain[i]),
            .tok_out (tok_chain[i+1]),
            .idx_out (idx_chain[i+1])
        );
    end

    assign tok_end = tok_chain[CACHE_ENTRIES];
    assign idx_end = idx_chain[CACHE_ENTRIES];

    // learn without a match: free entry, else the replace pointer
    always_comb
    begin
        wr.en    = tok_end.valid && tok_end.learn && !tok_end.hit;
        wr.ip    = tok_end.ip;
        wr.mac   = tok_end.mac;
        wr_idx   = tok_end.free_found ? idx_end : ptr_reg;
        ptr_next = ptr_reg;
        if (is_clear)
        begin
            ptr_next = '0;
        end
        else if (wr.en && !tok_end.free_found)
        begin
            ptr_next = (ptr_reg == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tok_launch.valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (tok_end.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_load = 1'b0;
        res_next = '0;
        if (tok_end.valid)
        begin
            res_load         = 1'b1;
            res_next.kind    = tok_end.learn ? KIND_VERDICT : KIND_LOOKUP;
            res_next.success = tok_end.learn ? 1'b1 : tok_end.hit;
            res_next.reply   = tok_end.learn && reply_reg;
            res_next.mac     = tok_end.mac;
            res_next.ip      = tok_end.learn ? tok_end.ip : 32'd0;
        end
        else if (is_last && !verdict.ok)
        begin
            // rejected packet: all-zero verdict
            res_load      = 1'b1;
            res_next.kind = KIND_VERDICT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (tok_launch.valid)
        begin
            reply_reg <= verdict.reply;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.result_kind  = res_reg.kind;
    assign results.success      = res_reg.success;
    assign results.reply_needed = res_reg.reply;
    assign results.mac          = res_reg.mac;
    assign results.ip           = res_reg.ip;

    `ASSERT_IMPL(a_launch_idle, tok_launch.valid, state_reg == ST_IDLE, "token launched while busy")
    `ASSERT_IMPL(a_end_walk, tok_end.valid, state_reg == ST_WALK, "token left the row while idle")
    `ASSERT_IMPL(a_slot_free, tok_end.valid, !out_valid_reg, "result slot full at end of walk")
    `ASSERT_CLK(a_ptr_range, ptr_reg <= IDX_W'(CACHE_ENTRIES - 1), "replace pointer out of range")
    `ASSERT_CLK(a_no_wr_clear, !(wr.en && is_clear), "cache write during clear")

endmodule
`default_nettype wire
